// ===== hdl/interval_window_sequence_grouper_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the interval window sequence grouper
// Shared concurrent checks, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_WINDOW_SEQUENCE_GROUPER_DEFINES_SVH
`define INTERVAL_WINDOW_SEQUENCE_GROUPER_DEFINES_SVH

// Same-cycle implication.
`define IWSG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iwsg: same-cycle check failed");

// Next-cycle implication.
`define IWSG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("iwsg: next-cycle check failed");

`endif

// ===== hdl/iwsg_pkg.sv =====
// ----------------------------------------------------------------------------
// Interval window sequence grouper package
// Payload structs, register indexes, result codes and controller links.
// ----------------------------------------------------------------------------
`default_nettype none

package iwsg_pkg;

  localparam int WORD_W    = 32;
  localparam int IN_COLS   = 4;
  localparam int MAX_SEQ   = 32;
  localparam int SEQ_W     = 6;
  localparam int COLS_W    = 3;
  localparam int POS_W     = 5;
  localparam int SEQNUM_W  = 16;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_SIZE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS_USED = 2'd3;

  // result error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_TIME_DEC = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG = 2'd2;

  typedef logic [IN_COLS-1:0][WORD_W-1:0] row_t;

  typedef struct packed {
    logic [WORD_W-1:0] timestamp;
    logic [WORD_W-1:0] col_a;
    logic [WORD_W-1:0] col_b;
    logic [WORD_W-1:0] col_c;
    logic [WORD_W-1:0] col_d;
    logic              end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [SEQNUM_W-1:0] seq_number;
    logic [POS_W-1:0]    position;
    logic [WORD_W-1:0]   out_a;
    logic [WORD_W-1:0]   out_b;
    logic [WORD_W-1:0]   out_c;
    logic [WORD_W-1:0]   out_d;
    logic                is_pad;
    logic                run_last;
    logic [1:0]          error_code;
  } out_item_t;

  typedef enum logic [1:0] {
    EK_ROW_PREV,
    EK_ROW_CUR,
    EK_PAD,
    EK_ERR_DEC
  } emit_kind_e;

  typedef struct packed {
    logic       capture;
    logic       calc_gap;
    logic       set_pgv;
    logic       emit;
    emit_kind_e kind;
    logic       last;
    logic       close_seq;
    logic       finish;
  } iwsg_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic dec;
    logic gap_valid;
    logic pgv;
    logic eos;
    logic pos_lt;
    logic pos_next_lt;
    logic out_free;
  } iwsg_sts_t;

endpackage

`default_nettype wire

// ===== hdl/iwsg_ctrl.sv =====
// ----------------------------------------------------------------------------
// Interval window sequence grouper controller
// Sequences capture, gap check, planning and result emission for one row.
// ----------------------------------------------------------------------------
`default_nettype none

module iwsg_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire iwsg_pkg::iwsg_sts_t sts_i,
  output iwsg_pkg::iwsg_cmd_t     cmd_o
);
  import iwsg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAP,
    S_PLAN,
    S_PREV,
    S_CUR,
    S_PAD,
    S_ERR,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   cur_pend_q, cur_pend_d;
  logic   close_pend_q, close_pend_d;
  logic   err_pend_q, err_pend_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d      = state_q;
    cur_pend_d   = cur_pend_q;
    close_pend_d = close_pend_q;
    err_pend_d   = err_pend_q;
    cmd_o        = '0;
    cmd_o.kind   = EK_ROW_PREV;

    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_GAP;
        end
      end
      S_GAP: begin
        cmd_o.calc_gap = 1'b1;
        state_d        = S_PLAN;
      end
      S_PLAN: begin
        priority if (!sts_i.have_prev) begin
          state_d = S_FIN;
        end else if (sts_i.dec) begin
          // close any open sequence, then flag the decrease
          cur_pend_d   = 1'b0;
          close_pend_d = sts_i.pgv;
          err_pend_d   = 1'b1;
          state_d      = sts_i.pgv ? S_PREV : S_ERR;
        end else if (sts_i.gap_valid) begin
          cmd_o.set_pgv = 1'b1;
          cur_pend_d    = sts_i.eos;
          close_pend_d  = sts_i.eos;
          err_pend_d    = 1'b0;
          state_d       = S_PREV;
        end else if (sts_i.pgv) begin
          cur_pend_d   = 1'b0;
          close_pend_d = 1'b1;
          err_pend_d   = 1'b0;
          state_d      = S_PREV;
        end else begin
          state_d = S_FIN;
        end
      end
      S_PREV: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = EK_ROW_PREV;
          cmd_o.last = !(cur_pend_q || (close_pend_q && sts_i.pos_next_lt) || err_pend_q);
          priority if (cur_pend_q) begin
            state_d = S_CUR;
          end else if (close_pend_q) begin
            state_d = S_PAD;
          end else if (err_pend_q) begin
            state_d = S_ERR;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_CUR: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = EK_ROW_CUR;
          cmd_o.last = !sts_i.pos_next_lt;
          state_d    = S_PAD;
        end
      end
      S_PAD: begin
        if (sts_i.pos_lt) begin
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = EK_PAD;
            cmd_o.last = !sts_i.pos_next_lt && !err_pend_q;
          end
        end else begin
          // padding done: advance the sequence number
          cmd_o.close_seq = 1'b1;
          state_d         = err_pend_q ? S_ERR : S_FIN;
        end
      end
      S_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = EK_ERR_DEC;
          cmd_o.last = 1'b1;
          state_d    = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_pend_q   <= 1'b0;
      close_pend_q <= 1'b0;
      err_pend_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_pend_q   <= cur_pend_d;
      close_pend_q <= close_pend_d;
      err_pend_q   <= err_pend_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/iwsg_datapath.sv =====
// ----------------------------------------------------------------------------
// Interval window sequence grouper datapath
// Registers, row and timestamp store, gap compare, counters, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "interval_window_sequence_grouper_defines.svh"

module iwsg_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [iwsg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [iwsg_pkg::WORD_W-1:0]     cfg_data_i,
  input  wire iwsg_pkg::in_item_t              in_data_i,
  input  wire iwsg_pkg::iwsg_cmd_t             cmd_i,
  output iwsg_pkg::iwsg_sts_t                  sts_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output iwsg_pkg::out_item_t                  out_data_o
);
  import iwsg_pkg::*;

  logic [WORD_W-1:0]   min_gap_q, max_gap_q;
  logic [SEQ_W-1:0]    seq_size_q;
  logic [COLS_W-1:0]   cols_used_q;

  logic [WORD_W-1:0]   prev_time_q, prev_time_d;
  row_t                prev_row_q, prev_row_d;
  logic                have_prev_q, have_prev_d;
  logic                pgv_q, pgv_d;
  logic [SEQ_W-1:0]    row_pos_q, row_pos_d;
  logic [SEQNUM_W-1:0] seq_count_q, seq_count_d;

  logic [WORD_W-1:0]   cur_time_q;
  row_t                cur_row_q, row_in;
  logic                cur_eos_q;
  logic [WORD_W-1:0]   gap_q;
  logic                dec_q;

  out_item_t           out_q, out_d;
  logic                out_valid_q;

  logic [SEQ_W-1:0]    eff_size;
  logic [COLS_W-1:0]   eff_cols;
  logic                pos_lt, pos_next_lt, out_free;
  row_t                emit_row;

  // clamp registers to their working range
  always_comb begin
    priority if (seq_size_q < SEQ_W'(2)) begin
      eff_size = SEQ_W'(2);
    end else if (seq_size_q > SEQ_W'(MAX_SEQ)) begin
      eff_size = SEQ_W'(MAX_SEQ);
    end else begin
      eff_size = seq_size_q;
    end
    priority if (cols_used_q == '0) begin
      eff_cols = COLS_W'(1);
    end else if (cols_used_q > COLS_W'(IN_COLS)) begin
      eff_cols = COLS_W'(IN_COLS);
    end else begin
      eff_cols = cols_used_q;
    end
  end

  // drop unused columns at capture
  always_comb begin
    row_in = {in_data_i.col_d, in_data_i.col_c, in_data_i.col_b, in_data_i.col_a};
    for (int j = 0; j < IN_COLS; j++) begin
      if (COLS_W'(j) >= eff_cols) begin
        row_in[j] = '0;
      end
    end
  end

  assign pos_lt      = (row_pos_q < eff_size);
  assign pos_next_lt = ((SEQ_W + 1)'(row_pos_q) + (SEQ_W + 1)'(1)) < (SEQ_W + 1)'(eff_size);
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o.have_prev   = have_prev_q;
    sts_o.dec         = dec_q;
    sts_o.gap_valid   = (gap_q > min_gap_q) && (gap_q < max_gap_q);
    sts_o.pgv         = pgv_q;
    sts_o.eos         = cur_eos_q;
    sts_o.pos_lt      = pos_lt;
    sts_o.pos_next_lt = pos_next_lt;
    sts_o.out_free    = out_free;
  end

  assign emit_row = (cmd_i.kind == EK_ROW_CUR) ? cur_row_q : prev_row_q;

  // result build and sequence state update
  always_comb begin
    out_d         = '0;
    out_d.seq_number = seq_count_q;
    out_d.run_last   = cmd_i.last;
    prev_time_d   = prev_time_q;
    prev_row_d    = prev_row_q;
    have_prev_d   = have_prev_q;
    pgv_d         = pgv_q;
    row_pos_d     = row_pos_q;
    seq_count_d   = seq_count_q;

    if (cmd_i.set_pgv) begin
      pgv_d = 1'b1;
    end

    if (cmd_i.emit) begin
      unique case (cmd_i.kind)
        EK_ROW_PREV, EK_ROW_CUR: begin
          if (pos_lt) begin
            out_d.position = row_pos_q[POS_W-1:0];
            out_d.out_a    = emit_row[0];
            out_d.out_b    = emit_row[1];
            out_d.out_c    = emit_row[2];
            out_d.out_d    = emit_row[3];
            row_pos_d      = row_pos_q + SEQ_W'(1);
          end else begin
            out_d.error_code = ERR_TOO_LONG;
          end
        end
        EK_PAD: begin
          out_d.position = row_pos_q[POS_W-1:0];
          out_d.is_pad   = 1'b1;
          row_pos_d      = row_pos_q + SEQ_W'(1);
        end
        EK_ERR_DEC: begin
          out_d.error_code = ERR_TIME_DEC;
        end
      endcase
    end

    if (cmd_i.close_seq) begin
      seq_count_d = seq_count_q + SEQNUM_W'(1);
      row_pos_d   = '0;
      pgv_d       = 1'b0;
    end

    if (cmd_i.finish) begin
      if (cur_eos_q) begin
        prev_time_d = '0;
        prev_row_d  = '0;
        have_prev_d = 1'b0;
        pgv_d       = 1'b0;
        row_pos_d   = '0;
        seq_count_d = '0;
      end else begin
        prev_time_d = cur_time_q;
        prev_row_d  = cur_row_q;
        have_prev_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_q   <= '0;
      max_gap_q   <= '1;
      seq_size_q  <= SEQ_W'(32);
      cols_used_q <= COLS_W'(1);
      prev_time_q <= '0;
      prev_row_q  <= '0;
      have_prev_q <= 1'b0;
      pgv_q       <= 1'b0;
      row_pos_q   <= '0;
      seq_count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MIN_GAP:      min_gap_q   <= cfg_data_i;
          CFG_MAX_GAP:      max_gap_q   <= cfg_data_i;
          CFG_SEQ_SIZE:     seq_size_q  <= cfg_data_i[SEQ_W-1:0];
          CFG_COLUMNS_USED: cols_used_q <= cfg_data_i[COLS_W-1:0];
        endcase
      end
      prev_time_q <= prev_time_d;
      prev_row_q  <= prev_row_d;
      have_prev_q <= have_prev_d;
      pgv_q       <= pgv_d;
      row_pos_q   <= row_pos_d;
      seq_count_q <= seq_count_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cur_time_q <= in_data_i.timestamp;
      cur_row_q  <= row_in;
      cur_eos_q  <= in_data_i.end_of_stream;
    end
    if (cmd_i.calc_gap) begin
      gap_q <= cur_time_q - prev_time_q;
      dec_q <= (cur_time_q < prev_time_q);
    end
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `IWSG_ASSERT_IMPL(a_no_overwrite, cmd_i.emit && out_valid_q, !out_stall_i)
  `IWSG_ASSERT_IMPL(a_pos_bound, 1'b1, row_pos_q <= SEQ_W'(MAX_SEQ))
  `IWSG_ASSERT_NEXT(a_seq_step, cmd_i.close_seq, seq_count_q == $past(seq_count_q) + SEQNUM_W'(1))

endmodule

`default_nettype wire

// ===== hdl/interval_window_sequence_grouper.sv =====
// ----------------------------------------------------------------------------
// Interval window sequence grouper
// Groups timestamped rows into numbered sequences of closely spaced events.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------
//  in       | input     | in_valid_i / in_stall_o   | in_data_i  (in_item_t)
//  out      | output    | out_valid_o / out_stall_i | out_data_o (out_item_t)
//  cfg      | input     | cfg_we_i, no wait         | cfg_idx_i, cfg_data_i
//
//  A row passes through the sequencer states in order: accept, gap subtract,
//  gap compare and plan, result emission, sequence close where needed, and
//  state update.
//  One result leaves per cycle through the output register; out_stall_i holds
//  the sequencer on its next result while the held one waits.
//  Async reset clears all but the payload registers and loads their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_window_sequence_grouper (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [iwsg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [iwsg_pkg::WORD_W-1:0]    cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire iwsg_pkg::in_item_t             in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output iwsg_pkg::out_item_t                 out_data_o
);
  import iwsg_pkg::*;

  iwsg_cmd_t cmd;
  iwsg_sts_t sts;

  iwsg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  iwsg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
